### hdl/mmcri_pkg.sv
// ----------------------------------------------------------------------------
// MMC card register interface package
// Shared types, command codes and fixed response words.
// ----------------------------------------------------------------------------
package mmcri_pkg;

  localparam int IDX_W       = 5;
  localparam int POS_W       = 41;
  localparam int QUEUE_DEPTH = 2;

  // configuration register indexes
  localparam logic [1:0] CFG_CARD_SIZE   = 2'd0;
  localparam logic [1:0] CFG_READ_BL_LEN = 2'd1;
  localparam logic [1:0] CFG_SECTOR_CNT  = 2'd2;

  // MMC command indexes
  localparam logic [5:0] MMC_GO_IDLE       = 6'd0;
  localparam logic [5:0] MMC_OP_COND       = 6'd1;
  localparam logic [5:0] MMC_GET_CID       = 6'd2;
  localparam logic [5:0] MMC_SET_RCA       = 6'd3;
  localparam logic [5:0] MMC_SLEEP_AWAKE   = 6'd5;
  localparam logic [5:0] MMC_SEL_CARD      = 6'd7;
  localparam logic [5:0] MMC_GET_EXT_CSD   = 6'd8;
  localparam logic [5:0] MMC_GET_CSD       = 6'd9;
  localparam logic [5:0] MMC_STOP_TRANS    = 6'd12;
  localparam logic [5:0] MMC_GET_STATUS    = 6'd13;
  localparam logic [5:0] MMC_READ_MULTI    = 6'd18;
  localparam logic [5:0] MMC_SET_BLK_COUNT = 6'd23;
  localparam logic [5:0] MMC_WRITE_MULTI   = 6'd25;
  localparam logic [5:0] MMC_IO_RW_DIRECT  = 6'd52;
  localparam logic [5:0] MMC_APP_PREFIX    = 6'd55;

  // fixed response words
  localparam logic [31:0] OCR_WORD   = 32'h80ff8000;
  localparam logic [31:0] CID_WORD0  = 32'h00000001;
  localparam logic [31:0] CID_WORD3  = 32'h15000000;
  localparam logic [31:0] CSD_WORD0  = 32'h92404001;
  localparam logic [31:0] CSD_WORD1  = 32'h124b97e3;
  localparam logic [31:0] CSD_WORD2  = 32'h0f508000;
  localparam logic [31:0] CSD_WORD3  = 32'h9026012a;

  // EXT_CSD byte offsets and contents
  localparam logic [31:0] EXT_OFF_REV     = 32'd192;
  localparam logic [31:0] EXT_OFF_SEC_CNT = 32'd212;
  localparam logic [31:0] EXT_OFF_LAST    = 32'd508;
  localparam logic [31:0] EXT_REV_WORD    = 32'd2;
  localparam logic [31:0] WORD_BYTES      = 32'd4;

  typedef enum logic [1:0] {
    CLS_CMD,
    CLS_QUIET,
    CLS_DATA,
    CLS_BAD
  } cls_e;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_OPCOND,
    OP_CID,
    OP_EXTCSD,
    OP_CSD,
    OP_STATUS,
    OP_RD_MULTI,
    OP_WR_MULTI,
    OP_BAD
  } op_e;

  typedef struct packed {
    logic             wr_acc;
    cls_e             cls;
    logic             in_range;
    logic [IDX_W-1:0] idx;
    logic [31:0]      wdata;
    logic [31:0]      sword;
  } item_t;

  typedef struct packed {
    logic [31:0]      read_data;
    logic             storage_read;
    logic             storage_write;
    logic [POS_W-1:0] storage_address;
    logic [31:0]      storage_write_data;
    logic             error;
  } result_t;

  typedef struct packed {
    logic [11:0] card_size;
    logic [3:0]  read_bl_len;
    logic [31:0] sector_count;
  } cfg_t;

  function automatic op_e mmc_decode(input logic [5:0] code);
    op_e op;
    unique case (code)
      MMC_GO_IDLE, MMC_SET_RCA, MMC_SLEEP_AWAKE, MMC_SEL_CARD,
      MMC_STOP_TRANS, MMC_IO_RW_DIRECT, MMC_APP_PREFIX,
      MMC_SET_BLK_COUNT:  op = OP_NOP;
      MMC_OP_COND:        op = OP_OPCOND;
      MMC_GET_CID:        op = OP_CID;
      MMC_GET_EXT_CSD:    op = OP_EXTCSD;
      MMC_GET_CSD:        op = OP_CSD;
      MMC_GET_STATUS:     op = OP_STATUS;
      MMC_READ_MULTI:     op = OP_RD_MULTI;
      MMC_WRITE_MULTI:    op = OP_WR_MULTI;
      default:            op = OP_BAD;
    endcase
    return op;
  endfunction

endpackage

### hdl/mmcri_front.sv
// ----------------------------------------------------------------------------
// MMC card register interface front end
// Accepts register accesses and classifies the offset for the back end.
// ----------------------------------------------------------------------------
module mmcri_front #(
  parameter int REG_WORDS  = 32,
  parameter int CMD_INDEX  = 0,
  parameter int ARG_INDEX  = 1,
  parameter int RESP_INDEX = 4,
  parameter int DATA_INDEX = 16
) (
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        kind_i,
  input  logic [mmcri_pkg::IDX_W-1:0] reg_index_i,
  input  logic [31:0]                 write_data_i,
  input  logic [31:0]                 storage_word_i,
  input  logic                        queue_full_i,
  output logic                        push_o,
  output mmcri_pkg::item_t            item_o
);
  import mmcri_pkg::*;

  localparam logic [IDX_W-1:0] CMD_IDX   = IDX_W'(CMD_INDEX);
  localparam logic [IDX_W-1:0] ARG_IDX   = IDX_W'(ARG_INDEX);
  localparam logic [IDX_W-1:0] RESP0_IDX = IDX_W'(RESP_INDEX);
  localparam logic [IDX_W-1:0] RESP1_IDX = IDX_W'(RESP_INDEX + 1);
  localparam logic [IDX_W-1:0] RESP2_IDX = IDX_W'(RESP_INDEX + 2);
  localparam logic [IDX_W-1:0] RESP3_IDX = IDX_W'(RESP_INDEX + 3);
  localparam logic [IDX_W-1:0] DATA_IDX  = IDX_W'(DATA_INDEX);

  cls_e cls;

  assign in_ready_o = !queue_full_i;
  assign push_o     = in_valid_i && !queue_full_i;

  // command decode wins over argument and responses, which win over data
  always_comb begin
    priority if (reg_index_i == CMD_IDX) begin
      cls = CLS_CMD;
    end else if (reg_index_i == ARG_IDX || reg_index_i == RESP0_IDX ||
                 reg_index_i == RESP1_IDX || reg_index_i == RESP2_IDX ||
                 reg_index_i == RESP3_IDX) begin
      cls = CLS_QUIET;
    end else if (reg_index_i == DATA_IDX) begin
      cls = CLS_DATA;
    end else begin
      cls = CLS_BAD;
    end
  end

  always_comb begin
    item_o.wr_acc   = kind_i;
    item_o.cls      = cls;
    item_o.in_range = int'(reg_index_i) < REG_WORDS;
    item_o.idx      = reg_index_i;
    item_o.wdata    = write_data_i;
    item_o.sword    = storage_word_i;
  end

endmodule

### hdl/mmcri_queue.sv
// ----------------------------------------------------------------------------
// MMC card register interface queue
// Short FIFO of classified accesses between front and back end.
// ----------------------------------------------------------------------------
module mmcri_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  mmcri_pkg::item_t item_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output mmcri_pkg::item_t item_o
);
  import mmcri_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == CNT_W'(QUEUE_DEPTH);
  assign valid_o = cnt_q != '0;
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + PTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

### hdl/mmcri_back.sv
// ----------------------------------------------------------------------------
// MMC card register interface back end
// Holds register file and card state, one access per cycle unless stalled.
// ----------------------------------------------------------------------------
module mmcri_back #(
  parameter int REG_WORDS  = 32,
  parameter int CMD_INDEX  = 0,
  parameter int ARG_INDEX  = 1,
  parameter int RESP_INDEX = 4,
  parameter int DATA_INDEX = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mmcri_pkg::cfg_t    cfg_i,
  input  logic               item_valid_i,
  input  mmcri_pkg::item_t   item_i,
  output logic               item_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mmcri_pkg::result_t result_o
);
  import mmcri_pkg::*;

  localparam int AW        = $clog2(REG_WORDS);
  localparam int AWX       = AW + IDX_W;
  localparam bit CMD_IN    = CMD_INDEX < REG_WORDS;
  localparam bit ARG_IN    = ARG_INDEX < REG_WORDS;
  localparam bit DATA_IN   = DATA_INDEX < REG_WORDS;
  localparam int CMD_SAFE  = CMD_IN ? CMD_INDEX : 0;
  localparam int ARG_SAFE  = ARG_IN ? ARG_INDEX : 0;
  localparam int DATA_SAFE = DATA_IN ? DATA_INDEX : 0;

  logic [31:0]      rf_q [REG_WORDS];
  logic [31:0]      rf_w [REG_WORDS];
  logic [31:0]      rf_d [REG_WORDS];
  logic             ext_q, ext_d;
  logic             wmode_q, wmode_d;
  logic [31:0]      off_q, off_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic             out_valid_q;
  result_t          res_q, res_d;

  logic [AWX-1:0]   idx_ext;
  logic [AW-1:0]    addr;
  logic [31:0]      cmd_word, arg_word, data_word;
  op_e              op;
  logic [3:0]       resp_we;
  logic [31:0]      resp_val [4];
  logic             data_we;
  logic [31:0]      data_val;
  logic [31:0]      ext_word;
  logic             fire;

  assign idx_ext = AWX'(item_i.idx);
  assign addr    = idx_ext[AW-1:0];

  // register file after the store of a write access
  always_comb begin
    for (int j = 0; j < REG_WORDS; j++) begin
      rf_w[j] = (item_i.wr_acc && item_i.in_range && addr == AW'(j)) ?
                item_i.wdata : rf_q[j];
    end
  end

  assign cmd_word  = CMD_IN  ? rf_w[AW'(CMD_SAFE)]  : '0;
  assign arg_word  = ARG_IN  ? rf_w[AW'(ARG_SAFE)]  : '0;
  assign data_word = DATA_IN ? rf_w[AW'(DATA_SAFE)] : '0;
  assign op        = mmc_decode(cmd_word[5:0]);

  always_comb begin
    priority if (off_q == EXT_OFF_REV) begin
      ext_word = EXT_REV_WORD;
    end else if (off_q == EXT_OFF_SEC_CNT) begin
      ext_word = cfg_i.sector_count;
    end else begin
      ext_word = '0;
    end
  end

  // access handler
  always_comb begin
    resp_we  = '0;
    for (int i = 0; i < 4; i++) begin
      resp_val[i] = '0;
    end
    data_we  = 1'b0;
    data_val = '0;
    ext_d    = ext_q;
    wmode_d  = wmode_q;
    off_d    = off_q;
    pos_d    = pos_q;
    res_d    = '0;
    unique case (item_i.cls)
      CLS_CMD: begin
        unique case (op)
          OP_NOP: begin
          end
          OP_OPCOND: begin
            resp_we[0]  = 1'b1;
            resp_val[0] = OCR_WORD;
          end
          OP_CID: begin
            resp_we     = 4'hf;
            resp_val[0] = CID_WORD0;
            resp_val[3] = CID_WORD3;
          end
          OP_EXTCSD: begin
            ext_d = 1'b1;
            off_d = '0;
          end
          OP_CSD: begin
            resp_we     = 4'hf;
            resp_val[0] = CSD_WORD0;
            resp_val[1] = CSD_WORD1 | {cfg_i.card_size[1:0], 30'b0};
            resp_val[2] = CSD_WORD2 |
                          {12'b0, cfg_i.read_bl_len, 6'b0, cfg_i.card_size[11:2]};
            resp_val[3] = CSD_WORD3;
          end
          OP_STATUS: begin
            resp_we = 4'hf;
          end
          OP_RD_MULTI, OP_WR_MULTI: begin
            off_d   = '0;
            pos_d   = {arg_word, 9'b0};
            wmode_d = op == OP_WR_MULTI;
          end
          OP_BAD: begin
            res_d.error = 1'b1;
          end
          default: begin
            res_d.error = 1'b1;
          end
        endcase
      end
      CLS_QUIET: begin
      end
      CLS_DATA: begin
        if (ext_q) begin
          data_we  = 1'b1;
          data_val = ext_word;
          if (off_q == EXT_OFF_LAST) begin
            ext_d = 1'b0;
          end
        end else begin
          res_d.storage_address = pos_q;
          if (!wmode_q) begin
            data_we            = 1'b1;
            data_val           = item_i.sword;
            res_d.storage_read = 1'b1;
          end else begin
            res_d.storage_write      = 1'b1;
            res_d.storage_write_data = data_word;
          end
          pos_d = pos_q + POS_W'(4);
        end
        off_d = off_q + WORD_BYTES;
      end
      CLS_BAD: begin
        res_d.error = 1'b1;
      end
      default: begin
        res_d.error = 1'b1;
      end
    endcase

    for (int j = 0; j < REG_WORDS; j++) begin
      rf_d[j] = rf_w[j];
      for (int i = 0; i < 4; i++) begin
        if (resp_we[i] && j == RESP_INDEX + i) begin
          rf_d[j] = resp_val[i];
        end
      end
      if (data_we && j == DATA_INDEX) begin
        rf_d[j] = data_val;
      end
    end

    // a read returns the register as the handler left it
    res_d.read_data = (!item_i.wr_acc && item_i.in_range) ? rf_d[addr] : '0;
  end

  assign fire        = item_valid_i && (!out_valid_q || out_ready_i);
  assign item_pop_o  = fire;
  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < REG_WORDS; j++) begin
        rf_q[j] <= '0;
      end
      ext_q       <= 1'b0;
      wmode_q     <= 1'b0;
      off_q       <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        for (int j = 0; j < REG_WORDS; j++) begin
          rf_q[j] <= rf_d[j];
        end
        ext_q   <= ext_d;
        wmode_q <= wmode_d;
        off_q   <= off_d;
        pos_q   <= pos_d;
      end
      out_valid_q <= fire || (out_valid_q && !out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

endmodule

### hdl/mmc_card_register_interface_top.sv
// ----------------------------------------------------------------------------
// MMC card register interface
// Register window of an emulated eMMC card with command and data handling.
// ----------------------------------------------------------------------------
// Each accepted register access gives exactly one result word. A front end
// classifies the register offset and places the access into a two-entry
// queue; the back end runs one access per clock, while the output is not
// stalled, against the register file and card state and parks the result
// in an output register. Sustained rate is one access per cycle while
// out_ready_i is held high, set by the back end that owns all card state;
// an access passes the queue entry, then the back end's output register.
// When the output stalls, two more accesses are taken before in_ready_o
// drops. Configuration writes take effect at once and must be issued while
// no access is in flight. The register file resets to zero; there is no
// clearing pass after reset.
module mmc_card_register_interface_top #(
  parameter int REG_WORDS  = 32,
  parameter int CMD_INDEX  = 0,
  parameter int ARG_INDEX  = 1,
  parameter int RESP_INDEX = 4,
  parameter int DATA_INDEX = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [4:0]  reg_index_i,
  input  logic [31:0] write_data_i,
  input  logic [31:0] storage_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] read_data_o,
  output logic        storage_read_o,
  output logic        storage_write_o,
  output logic [40:0] storage_address_o,
  output logic [31:0] storage_write_data_o,
  output logic        error_o
);
  import mmcri_pkg::*;

  cfg_t    cfg_q;
  item_t   push_item, head_item;
  logic    push, queue_full, head_valid, pop;
  result_t result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.card_size    <= 12'd4095;
      cfg_q.read_bl_len  <= 4'd9;
      cfg_q.sector_count <= 32'd1048576;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_CARD_SIZE:   cfg_q.card_size    <= cfg_wdata_i[11:0];
        CFG_READ_BL_LEN: cfg_q.read_bl_len  <= cfg_wdata_i[3:0];
        CFG_SECTOR_CNT:  cfg_q.sector_count <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  mmcri_front #(
    .REG_WORDS  (REG_WORDS),
    .CMD_INDEX  (CMD_INDEX),
    .ARG_INDEX  (ARG_INDEX),
    .RESP_INDEX (RESP_INDEX),
    .DATA_INDEX (DATA_INDEX)
  ) u_front (
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .reg_index_i    (reg_index_i),
    .write_data_i   (write_data_i),
    .storage_word_i (storage_word_i),
    .queue_full_i   (queue_full),
    .push_o         (push),
    .item_o         (push_item)
  );

  mmcri_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (queue_full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .item_o  (head_item)
  );

  mmcri_back #(
    .REG_WORDS  (REG_WORDS),
    .CMD_INDEX  (CMD_INDEX),
    .ARG_INDEX  (ARG_INDEX),
    .RESP_INDEX (RESP_INDEX),
    .DATA_INDEX (DATA_INDEX)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (head_valid),
    .item_i       (head_item),
    .item_pop_o   (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .result_o     (result)
  );

  assign read_data_o          = result.read_data;
  assign storage_read_o       = result.storage_read;
  assign storage_write_o      = result.storage_write;
  assign storage_address_o    = result.storage_address;
  assign storage_write_data_o = result.storage_write_data;
  assign error_o              = result.error;

`ifndef SYNTHESIS
  // a word moves in one direction only
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(storage_read_o && storage_write_o))
    else $error("storage read and write in the same result");

  // a rejected access touches no storage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && error_o) |-> (!storage_read_o && !storage_write_o))
    else $error("storage transfer on an error result");

  // address shows only with a transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !storage_read_o && !storage_write_o) |->
      (storage_address_o == '0))
    else $error("storage address without a transfer");

  // queue fills only behind a stalled output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_o) |-> $past(out_valid_o && !out_ready_i))
    else $error("input stalled while output was free");
`endif

endmodule
